@@ hw/rtl/name_based_uuid_v5_generator_macros.svh @@
// Assertion helpers for the RTL.
`ifndef NAME_BASED_UUID_V5_GENERATOR_MACROS_SVH
`define NAME_BASED_UUID_V5_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define UUID5_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uuid5 check failed");

// Next-cycle implication, checked out of reset.
`define UUID5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uuid5 check failed");

`endif

@@ hw/rtl/uuid5_pkg.sv @@
`timescale 1ns / 1ps
package uuid5_pkg;

	typedef struct packed {
		logic [7:0] name_byte;
		logic       byte_valid;
		logic       last_byte;
	} name_in_t;

	typedef struct packed {
		logic [63:0] uuid_high;
		logic [63:0] uuid_low;
	} uuid_out_t;

	// config register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NS_HIGH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NS_LOW  = 1'd1;

	// byte source select for absorb
	localparam logic [2:0] BSEL_NS   = 3'd0;
	localparam logic [2:0] BSEL_NAME = 3'd1;
	localparam logic [2:0] BSEL_PAD  = 3'd2;
	localparam logic [2:0] BSEL_ZERO = 3'd3;
	localparam logic [2:0] BSEL_LEN  = 3'd4;

	localparam logic [6:0] LAST_ROUND = 7'd79;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	typedef struct packed {
		logic       item_load;
		logic       ns_load;
		logic       absorb;
		logic [2:0] bsel;
		logic       len_load;
		logic       round_en;
		logic [6:0] round;
		logic       chain_add;
		logic       msg_restart;
		logic       out_load;
	} uuid5_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       item_valid;
		logic       item_last;
	} uuid5_stat_t;

endpackage

@@ hw/rtl/uuid5_ctrl.sv @@
`timescale 1ns / 1ps
module uuid5_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  uuid5_pkg::uuid5_stat_t stat,
	output uuid5_pkg::uuid5_cmd_t  cmd
);
	import uuid5_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PREFIX = 4'd1;
	localparam logic [3:0] S_NAME   = 4'd2;
	localparam logic [3:0] S_PAD80  = 4'd3;
	localparam logic [3:0] S_PADZ   = 4'd4;
	localparam logic [3:0] S_LEN    = 4'd5;
	localparam logic [3:0] S_ROUND  = 4'd6;
	localparam logic [3:0] S_FINAL  = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q, state_d, ret_q, ret_d, go;
	logic [3:0] cnt_q, cnt_d;
	logic [6:0] round_q, round_d;
	logic       prefix_q, prefix_d;
	logic       oval_q, oval_d;
	logic       take;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = oval_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		ret_d    = ret_q;
		cnt_d    = cnt_q;
		round_d  = round_q;
		prefix_d = prefix_q;
		oval_d   = oval_q & ~out_ready;
		take     = 1'b0;
		go       = state_q;
		cmd.round = round_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					cnt_d = '0;
					if (prefix_q) begin
						state_d = S_NAME;
					end else begin
						cmd.ns_load = 1'b1;
						state_d = S_PREFIX;
					end
				end
			end
			S_PREFIX: begin
				take = 1'b1;
				cmd.bsel = BSEL_NS;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					prefix_d = 1'b1;
					go = S_NAME;
				end
			end
			S_NAME: begin
				go = stat.item_last ? S_PAD80 : S_IDLE;
				if (stat.item_valid) begin
					take = 1'b1;
					cmd.bsel = BSEL_NAME;
				end else begin
					state_d = go;
				end
			end
			S_PAD80: begin
				take = 1'b1;
				cmd.bsel = BSEL_PAD;
				cmd.len_load = 1'b1;
				go = S_PADZ;
			end
			S_PADZ: begin
				if (stat.pos == 6'd56) begin
					cnt_d = '0;
					state_d = S_LEN;
				end else begin
					take = 1'b1;
					cmd.bsel = BSEL_ZERO;
				end
			end
			S_LEN: begin
				take = 1'b1;
				cmd.bsel = BSEL_LEN;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd7) go = S_DONE;
			end
			S_ROUND: begin
				cmd.round_en = 1'b1;
				round_d = round_q + 7'd1;
				if (round_q == LAST_ROUND) state_d = S_FINAL;
			end
			S_FINAL: begin
				cmd.chain_add = 1'b1;
				state_d = ret_q;
			end
			S_DONE: begin
				if (!oval_q || out_ready) begin
					cmd.out_load = 1'b1;
					cmd.msg_restart = 1'b1;
					prefix_d = 1'b0;
					oval_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// a full block triggers compression, then resumes at go
		if (take) begin
			cmd.absorb = 1'b1;
			if (stat.pos == 6'd63) begin
				ret_d   = go;
				round_d = '0;
				state_d = S_ROUND;
			end else begin
				state_d = go;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			cnt_q    <= '0;
			round_q  <= '0;
			prefix_q <= 1'b0;
			oval_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			cnt_q    <= cnt_d;
			round_q  <= round_d;
			prefix_q <= prefix_d;
			oval_q   <= oval_d;
		end
	end

endmodule

@@ hw/rtl/uuid5_dp.sv @@
`timescale 1ns / 1ps
module uuid5_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  uuid5_pkg::name_in_t    in_word,
	input  logic [63:0]            ns_high,
	input  logic [63:0]            ns_low,
	input  uuid5_pkg::uuid5_cmd_t  cmd,
	output uuid5_pkg::uuid5_stat_t stat,
	output uuid5_pkg::uuid_out_t   out_word
);
	import uuid5_pkg::*;

	name_in_t     item_q;
	logic [127:0] ns_q;
	logic [63:0]  len_q;
	logic [63:0]  msg_q;
	logic [511:0] blk_q;
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	uuid_out_t    out_q;

	logic [7:0]  bval;
	logic [31:0] f, k, tmp, wnew, sched;

	assign stat.pos        = msg_q[5:0];
	assign stat.item_valid = item_q.byte_valid;
	assign stat.item_last  = item_q.last_byte;
	assign out_word        = out_q;

	always_comb begin
		unique case (cmd.bsel)
			BSEL_NS:   bval = ns_q[127:120];
			BSEL_NAME: bval = item_q.name_byte;
			BSEL_PAD:  bval = 8'h80;
			BSEL_LEN:  bval = len_q[63:56];
			default:   bval = 8'h00;
		endcase
	end

	// window of 16 schedule words; word i sits at [511-32i -: 32]
	assign sched = blk_q[511:480] ^ blk_q[447:416] ^ blk_q[255:224] ^ blk_q[95:64];
	assign wnew  = {sched[30:0], sched[31]};

	always_comb begin
		if (cmd.round < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (cmd.round < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (cmd.round < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + blk_q[511:480];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_q  <= '0;
			h_q[0] <= H0;
			h_q[1] <= H1;
			h_q[2] <= H2;
			h_q[3] <= H3;
			h_q[4] <= H4;
		end else begin
			if (cmd.msg_restart) begin
				msg_q  <= '0;
				h_q[0] <= H0;
				h_q[1] <= H1;
				h_q[2] <= H2;
				h_q[3] <= H3;
				h_q[4] <= H4;
			end else begin
				if (cmd.absorb) msg_q <= msg_q + 64'd1;
				if (cmd.chain_add) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) item_q <= in_word;
		if (cmd.ns_load) ns_q <= {ns_high, ns_low};
		else if (cmd.absorb && cmd.bsel == BSEL_NS) ns_q <= {ns_q[119:0], 8'h00};
		if (cmd.len_load) len_q <= {msg_q[60:0], 3'b000};
		else if (cmd.absorb && cmd.bsel == BSEL_LEN) len_q <= {len_q[55:0], 8'h00};
		if (cmd.absorb) blk_q <= {blk_q[503:0], bval};
		else if (cmd.round_en) blk_q <= {blk_q[479:0], wnew};
		if (cmd.absorb && msg_q[5:0] == 6'd63) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round_en) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= tmp;
		end
		if (cmd.out_load) begin
			out_q.uuid_high <= {h_q[0], h_q[1][31:16], 4'h5, h_q[1][11:0]};
			out_q.uuid_low  <= {2'b10, h_q[2][29:0], h_q[3]};
		end
	end

endmodule

@@ hw/rtl/name_based_uuid_v5_generator.sv @@
`timescale 1ns / 1ps
// Version 5 (SHA-1, name-based) UUID generator. Load the namespace UUID in
// network order into namespace_high/namespace_low through the cfg port, then
// stream the name one byte per word on the input channel; flag the final word
// with last_byte (a word with byte_valid low and last_byte high ends an empty
// name). The namespace is sampled at the first word of each name. The UUID
// comes out as one word, canonical byte order, version 5 and variant 10 set.
// Each name word is accepted, then absorbed; the first word of a name also
// absorbs the namespace bytes before it; every full 64-byte block runs the
// SHA-1 round loop (one round per cycle) and then the chain add. Closing a
// name absorbs the padding and length bytes, ends the zero fill and loads the
// UUID, with one or two compressions along the way. The next name word is
// taken while the UUID waits downstream; a name that closes while an earlier
// UUID is still unaccepted holds in the load step until that UUID leaves.
`include "name_based_uuid_v5_generator_macros.svh"
module name_based_uuid_v5_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  uuid5_pkg::name_in_t             in_word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output uuid5_pkg::uuid_out_t            out_word,
	input  logic                            cfg_we,
	input  logic [uuid5_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_data
);
	import uuid5_pkg::*;

	logic [63:0] ns_high_q, ns_low_q;
	uuid5_cmd_t  cmd;
	uuid5_stat_t stat;

	// namespace registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_high_q <= '0;
			ns_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NS_HIGH: ns_high_q <= cfg_data;
				REG_NS_LOW:  ns_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	uuid5_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	uuid5_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.ns_high  (ns_high_q),
		.ns_low   (ns_low_q),
		.cmd      (cmd),
		.stat     (stat),
		.out_word (out_word)
	);

	`UUID5_ASSERT_NOW(a_version, clk, arst_n, out_valid, out_word.uuid_high[15:12] == 4'h5)
	`UUID5_ASSERT_NOW(a_variant, clk, arst_n, out_valid, out_word.uuid_low[63:62] == 2'b10)
	`UUID5_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule
